[src/fpmlp_pkg.sv]
package fpmlp_pkg;

  localparam int DEF_NUM_LAYERS  = 3;
  localparam int DEF_MAX_LAYER   = 32;
  localparam int DEF_INPUT_SIZE  = 32;
  localparam int DEF_OUTPUT_SIZE = 3;

  localparam int WSLICE     = 1024;
  localparam int BUF_DEPTH  = 32;
  localparam int BUF_AW     = 5;
  localparam int W_ADDR_W   = 12;
  localparam int B_ADDR_W   = 7;
  localparam int BIAS_MULT  = 100;

  localparam logic [5:0]  SIZE0_RST = 6'd32;
  localparam logic [5:0]  SIZE1_RST = 6'd32;
  localparam logic [5:0]  SIZE2_RST = 6'd3;
  localparam logic [5:0]  SIZE3_RST = 6'd3;
  localparam logic [15:0] SCALE_RST = 16'd100;

  localparam logic [2:0] CFG_SIZE0 = 3'd0;
  localparam logic [2:0] CFG_SIZE1 = 3'd1;
  localparam logic [2:0] CFG_SIZE2 = 3'd2;
  localparam logic [2:0] CFG_SIZE3 = 3'd3;
  localparam logic [2:0] CFG_SCALE = 3'd4;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_FEATURE = 2'd2,
    OP_RUN     = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [1:0]         layer_sel;
    logic [9:0]         entry_addr;
    logic signed [31:0] data_value;
  } in_word_t;

  typedef struct packed {
    logic [4:0]         out_index;
    logic signed [31:0] out_value;
    logic               out_last;
  } out_word_t;

  typedef struct packed {
    logic                feat_re;
    logic [BUF_AW-1:0]   feat_raddr;
    logic                prev_re;
    logic [BUF_AW-1:0]   prev_raddr;
    logic                prev_we;
    logic [BUF_AW-1:0]   prev_waddr;
    logic                prev_wsrc;
    logic                curr_re;
    logic [BUF_AW-1:0]   curr_raddr;
    logic                curr_we;
    logic [BUF_AW-1:0]   curr_waddr;
    logic                w_re;
    logic [W_ADDR_W-1:0] w_raddr;
    logic                b_re;
    logic [B_ADDR_W-1:0] b_raddr;
    logic                mac_issue;
    logic                acc_clr;
    logic                bias_add;
    logic                div_start;
    logic                relu;
  } dp_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic div_busy;
  } dp_status_t;

  function automatic logic [5:0] eff_size(input logic [5:0] s, input int max_layer);
    logic [5:0] r;
    r = s;
    if (s == 6'd0) r = 6'd1;
    if (int'(s) > max_layer) r = 6'(max_layer);
    return r;
  endfunction

endpackage

[src/fpmlp_ram.sv]
module fpmlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fpmlp_datapath.sv]
module fpmlp_datapath #(
  parameter int NUM_LAYERS = fpmlp_pkg::DEF_NUM_LAYERS,
  parameter int MAX_LAYER  = fpmlp_pkg::DEF_MAX_LAYER,
  parameter int INPUT_SIZE = fpmlp_pkg::DEF_INPUT_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load_en,
  input  fpmlp_pkg::in_word_t   request,
  input  logic [15:0]           scale,
  input  fpmlp_pkg::dp_cmd_t    cmd,
  output fpmlp_pkg::dp_status_t status,
  output logic signed [31:0]    act_out
);
  import fpmlp_pkg::*;

  localparam int W_DEPTH = NUM_LAYERS * WSLICE;
  localparam int W_AW    = $clog2(W_DEPTH);
  localparam int B_DEPTH = NUM_LAYERS * BUF_DEPTH;
  localparam int B_AW    = $clog2(B_DEPTH);

  logic [W_ADDR_W-1:0] w_full;
  logic [B_ADDR_W-1:0] b_full;
  logic                w_we, b_we, f_we;
  logic [15:0]         w_rdata, b_rdata;
  logic [31:0]         f_rdata, prev_rdata, curr_rdata, prev_wdata;

  logic        v1, v2;
  logic [31:0] prod, acc, w_ext, b_ext, bias_scaled;

  logic [31:0] dq;
  logic [15:0] rem, dvs;
  logic [5:0]  cnt;
  logic        neg;
  logic [16:0] trial;
  logic        ge;
  logic [31:0] quot;

  assign w_full = {request.layer_sel, request.entry_addr};
  assign b_full = {request.layer_sel, request.entry_addr[BUF_AW-1:0]};
  assign w_we = load_en && request.opcode == OP_WEIGHT && int'(request.layer_sel) < NUM_LAYERS;
  assign b_we = load_en && request.opcode == OP_BIAS && int'(request.layer_sel) < NUM_LAYERS
                && int'(request.entry_addr) < MAX_LAYER;
  assign f_we = load_en && request.opcode == OP_FEATURE
                && int'(request.entry_addr) < INPUT_SIZE;

  fpmlp_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_full[W_AW-1:0]), .wdata(request.data_value[15:0]),
    .re(cmd.w_re), .raddr(cmd.w_raddr[W_AW-1:0]), .rdata(w_rdata)
  );

  fpmlp_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bias (
    .clk(clk), .we(b_we), .waddr(b_full[B_AW-1:0]), .wdata(request.data_value[15:0]),
    .re(cmd.b_re), .raddr(cmd.b_raddr[B_AW-1:0]), .rdata(b_rdata)
  );

  fpmlp_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH)) u_feature (
    .clk(clk), .we(f_we), .waddr(request.entry_addr[BUF_AW-1:0]),
    .wdata(request.data_value), .re(cmd.feat_re), .raddr(cmd.feat_raddr), .rdata(f_rdata)
  );

  assign prev_wdata = cmd.prev_wsrc ? curr_rdata : f_rdata;

  fpmlp_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH)) u_prev (
    .clk(clk), .we(cmd.prev_we), .waddr(cmd.prev_waddr), .wdata(prev_wdata),
    .re(cmd.prev_re), .raddr(cmd.prev_raddr), .rdata(prev_rdata)
  );

  fpmlp_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH)) u_curr (
    .clk(clk), .we(cmd.curr_we), .waddr(cmd.curr_waddr), .wdata(quot),
    .re(cmd.curr_re), .raddr(cmd.curr_raddr), .rdata(curr_rdata)
  );

  assign w_ext       = {{16{w_rdata[15]}}, w_rdata};
  assign b_ext       = {{16{b_rdata[15]}}, b_rdata};
  assign bias_scaled = b_ext * 32'(BIAS_MULT);

  assign trial = {rem, dq[31]};
  assign ge    = trial >= {1'b0, dvs};
  assign quot  = neg ? (32'd0 - dq) : dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      cnt <= 6'd0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
      if (cmd.div_start) begin
        cnt <= 6'd32;
      end else if (cnt != 6'd0) begin
        cnt <= cnt - 6'd1;
      end
    end
    prod <= w_ext * prev_rdata;
    if (cmd.acc_clr) begin
      acc <= 32'd0;
    end else if (v2) begin
      acc <= acc + prod;
    end else if (cmd.bias_add) begin
      acc <= acc + bias_scaled;
    end
    if (cmd.div_start) begin
      dvs <= (scale == 16'd0) ? 16'd1 : scale;
      rem <= 16'd0;
      if (cmd.relu && acc[31]) begin
        dq  <= 32'd0;
        neg <= 1'b0;
      end else begin
        dq  <= acc[31] ? (32'd0 - acc) : acc;
        neg <= acc[31];
      end
    end else if (cnt != 6'd0) begin
      rem <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      dq  <= {dq[30:0], ge};
    end
  end

  assign status.mac_busy = v1 | v2;
  assign status.div_busy = cnt != 6'd0;
  assign act_out         = prev_rdata;

endmodule

[src/fpmlp_ctrl.sv]
module fpmlp_ctrl #(
  parameter int NUM_LAYERS  = fpmlp_pkg::DEF_NUM_LAYERS,
  parameter int MAX_LAYER   = fpmlp_pkg::DEF_MAX_LAYER,
  parameter int INPUT_SIZE  = fpmlp_pkg::DEF_INPUT_SIZE,
  parameter int OUTPUT_SIZE = fpmlp_pkg::DEF_OUTPUT_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start_run,
  input  logic [3:0][5:0]       sizes,
  input  fpmlp_pkg::dp_status_t status,
  output fpmlp_pkg::dp_cmd_t    cmd,
  output logic                  busy,
  output logic                  done,
  output logic [4:0]            out_index,
  output logic                  out_last
);
  import fpmlp_pkg::*;

  localparam logic [1:0]        LAST_LAYER = 2'(NUM_LAYERS - 1);
  localparam logic [BUF_AW-1:0] LAST_IN    = BUF_AW'(INPUT_SIZE - 1);
  localparam logic [BUF_AW-1:0] LAST_OUT   = BUF_AW'(OUTPUT_SIZE - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_COPYF, S_NSTART, S_MAC, S_DRAIN, S_BIAS,
    S_DIVGO, S_DIV, S_WRITE, S_COPYA, S_LNEXT, S_OUT
  } state_t;

  state_t            state;
  logic [1:0]        layer;
  logic [BUF_AW-1:0] i, n, c, k, cp_addr;
  logic [5:0]        prev_size, size;
  logic [9:0]        base;
  logic              cp_wr, cp_src;

  assign size = eff_size(sizes[layer], MAX_LAYER);
  assign busy = state != S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.feat_re    = state == S_COPYF;
    cmd.feat_raddr = i;
    cmd.prev_re    = state == S_MAC || state == S_OUT;
    cmd.prev_raddr = (state == S_MAC) ? c : k;
    cmd.prev_we    = cp_wr;
    cmd.prev_waddr = cp_addr;
    cmd.prev_wsrc  = cp_src;
    cmd.curr_re    = state == S_COPYA;
    cmd.curr_raddr = i;
    cmd.curr_we    = state == S_WRITE;
    cmd.curr_waddr = n;
    cmd.w_re       = state == S_MAC;
    cmd.w_raddr    = {layer, base + {5'd0, c}};
    cmd.b_re       = state == S_NSTART;
    cmd.b_raddr    = {layer, n};
    cmd.mac_issue  = state == S_MAC;
    cmd.acc_clr    = state == S_NSTART;
    cmd.bias_add   = state == S_BIAS;
    cmd.div_start  = state == S_DIVGO;
    cmd.relu       = layer != LAST_LAYER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cp_wr <= 1'b0;
      done  <= 1'b0;
    end else begin
      cp_wr     <= state == S_COPYF || state == S_COPYA;
      cp_addr   <= i;
      cp_src    <= state == S_COPYA;
      done      <= state == S_OUT;
      out_index <= k;
      out_last  <= k == LAST_OUT;
      case (state)
        S_IDLE: begin
          if (start_run) begin
            i     <= '0;
            state <= S_COPYF;
          end
        end
        S_COPYF: begin
          if (i == LAST_IN) begin
            layer     <= 2'd0;
            prev_size <= 6'(INPUT_SIZE);
            n         <= '0;
            base      <= 10'd0;
            state     <= S_NSTART;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_NSTART: begin
          c     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if ({1'b0, c} == prev_size - 6'd1) begin
            state <= S_DRAIN;
          end else begin
            c <= c + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!status.mac_busy) begin
            state <= S_BIAS;
          end
        end
        S_BIAS:  state <= S_DIVGO;
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (!status.div_busy) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if ({1'b0, n} == size - 6'd1) begin
            i     <= '0;
            state <= S_COPYA;
          end else begin
            n     <= n + 1'b1;
            base  <= base + {4'd0, prev_size};
            state <= S_NSTART;
          end
        end
        S_COPYA: begin
          if ({1'b0, i} == size - 6'd1) begin
            state <= S_LNEXT;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_LNEXT: begin
          prev_size <= size;
          n         <= '0;
          base      <= 10'd0;
          if (layer == LAST_LAYER) begin
            k     <= '0;
            state <= S_OUT;
          end else begin
            layer <= layer + 2'd1;
            state <= S_NSTART;
          end
        end
        S_OUT: begin
          if (k == LAST_OUT) begin
            state <= S_IDLE;
          end else begin
            k <= k + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/fixed_point_mlp_inference_core.sv]
// Fixed-point dense network, evaluated one layer and one neuron at a time.
// Request channel: a word is taken when start is high and busy is low. Weight,
// bias and feature writes give no result. A run word raises busy until the run is
// finished; further words wait for busy to fall. A run copies the features, then
// for every neuron issues one multiply-accumulate per input of its layer through a
// single multiplier and lets it drain, adds the bias and divides by the scale in a
// one-bit-per-cycle divider, then copies each finished layer into the input buffer.
// Results: OUTPUT_SIZE words on consecutive cycles, each shown for one cycle with
// done high, the last with out_last set. The receiver cannot stall them.
// Configuration: cfg_valid with cfg_index and cfg_data, always ready; write only
// while idle. Reset restores the register defaults; the stores hold no valid
// contents until written.
module fixed_point_mlp_inference_core #(
  parameter int NUM_LAYERS  = fpmlp_pkg::DEF_NUM_LAYERS,
  parameter int MAX_LAYER   = fpmlp_pkg::DEF_MAX_LAYER,
  parameter int INPUT_SIZE  = fpmlp_pkg::DEF_INPUT_SIZE,
  parameter int OUTPUT_SIZE = fpmlp_pkg::DEF_OUTPUT_SIZE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fpmlp_pkg::in_word_t  request,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 done,
  output fpmlp_pkg::out_word_t result
);
  import fpmlp_pkg::*;

  logic [3:0][5:0]    size_cfg;
  logic [15:0]        scale;
  logic               load_en, start_run;
  dp_cmd_t            cmd;
  dp_status_t         status;
  logic [4:0]         res_index;
  logic signed [31:0] res_value;
  logic               res_last;

  assign cfg_ready = 1'b1;
  assign load_en   = start && !busy && request.opcode != OP_RUN;
  assign start_run = start && !busy && request.opcode == OP_RUN;
  assign result    = {res_index, res_value, res_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg[0] <= SIZE0_RST;
      size_cfg[1] <= SIZE1_RST;
      size_cfg[2] <= SIZE2_RST;
      size_cfg[3] <= SIZE3_RST;
      scale       <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE0: size_cfg[0] <= cfg_data[5:0];
        CFG_SIZE1: size_cfg[1] <= cfg_data[5:0];
        CFG_SIZE2: size_cfg[2] <= cfg_data[5:0];
        CFG_SIZE3: size_cfg[3] <= cfg_data[5:0];
        CFG_SCALE: scale       <= cfg_data;
        default: ;
      endcase
    end
  end

  fpmlp_ctrl #(
    .NUM_LAYERS(NUM_LAYERS), .MAX_LAYER(MAX_LAYER),
    .INPUT_SIZE(INPUT_SIZE), .OUTPUT_SIZE(OUTPUT_SIZE)
  ) u_ctrl (
    .clk(clk), .rst(rst), .start_run(start_run), .sizes(size_cfg), .status(status),
    .cmd(cmd), .busy(busy), .done(done), .out_index(res_index),
    .out_last(res_last)
  );

  fpmlp_datapath #(
    .NUM_LAYERS(NUM_LAYERS), .MAX_LAYER(MAX_LAYER), .INPUT_SIZE(INPUT_SIZE)
  ) u_dp (
    .clk(clk), .rst(rst), .load_en(load_en), .request(request), .scale(scale),
    .cmd(cmd), .status(status), .act_out(res_value)
  );

endmodule

[src/fpmlp_checker.sv]
module fpmlp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input fpmlp_pkg::in_word_t  request,
  input logic                 done,
  input fpmlp_pkg::out_word_t result
);
  import fpmlp_pkg::*;

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.opcode == OP_RUN |=> busy)
    else $error("run word did not raise busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word outside a run");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    done && !result.out_last |=> done)
    else $error("result burst broken before last word");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    done && result.out_last |=> !done)
    else $error("result word after last word");

endmodule

bind fixed_point_mlp_inference_core fpmlp_checker u_fpmlp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
  .done(done), .result(result)
);

[sim/fixed_point_mlp_inference_core_tb.sv]
`timescale 1ns / 100ps

module fixed_point_mlp_inference_core_tb;
  import fpmlp_pkg::*;

  localparam int NL = DEF_NUM_LAYERS;
  localparam int ML = DEF_MAX_LAYER;
  localparam int NIN = DEF_INPUT_SIZE;
  localparam int NOUT = DEF_OUTPUT_SIZE;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {K_WORD, K_CFG, K_DRAIN, K_HOLD} kind_t;

  typedef struct {
    kind_t       kind;
    in_word_t    word;
    logic [2:0]  idx;
    logic [15:0] data;
    int          gap;
  } pending_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    request;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        done;
  out_word_t   result;

  pending_t  pend_q[$];
  out_word_t expected_outputs[$];

  logic [15:0] weight_mem[NL*WSLICE];
  logic [15:0] bias_mem[NL*ML];
  logic [31:0] feature_mem[BUF_DEPTH];
  logic [31:0] prev_act[BUF_DEPTH];
  logic [31:0] curr_act[BUF_DEPTH];
  logic [5:0]  size_reg[4];
  logic [15:0] scale_reg;

  int errors = 0;
  int runs_seen = 0;
  int words_checked = 0;
  int cycles = 0;

  pending_t cur;
  logic     cur_valid;
  int       wait_cnt;

  fixed_point_mlp_inference_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int layer_neurons(int layer);
    int s;
    s = size_reg[layer];
    if (s == 0) s = 1;
    if (s > ML) s = ML;
    return s;
  endfunction

  function automatic void evaluate_network();
    int prev_size;
    int size;
    logic [31:0] acc;
    logic [31:0] w;
    logic signed [31:0] q;
    int div;
    prev_size = NIN;
    for (int i = 0; i < NIN; i++) prev_act[i] = feature_mem[i];
    for (int i = 0; i < BUF_DEPTH; i++) curr_act[i] = '0;
    div = (scale_reg == 0) ? 1 : int'(scale_reg);
    for (int l = 0; l < NL; l++) begin
      size = layer_neurons(l);
      for (int n = 0; n < size; n++) begin
        acc = '0;
        for (int c = 0; c < prev_size; c++) begin
          w = {{16{weight_mem[l*WSLICE + ((prev_size*n + c) % WSLICE)][15]}},
               weight_mem[l*WSLICE + ((prev_size*n + c) % WSLICE)]};
          acc = acc + w * prev_act[c];
        end
        w = {{16{bias_mem[l*ML + n][15]}}, bias_mem[l*ML + n]};
        acc = acc + w * 32'(BIAS_MULT);
        if (l + 1 < NL && acc[31]) acc = '0;
        q = $signed(acc) / div;
        curr_act[n] = q;
      end
      for (int n = 0; n < size; n++) prev_act[n] = curr_act[n];
      prev_size = size;
    end
  endfunction

  function automatic void predict_word(in_word_t w);
    out_word_t o;
    case (w.opcode)
      OP_WEIGHT: begin
        if (w.layer_sel < NL) weight_mem[w.layer_sel*WSLICE + w.entry_addr] = w.data_value[15:0];
      end
      OP_BIAS: begin
        if (w.layer_sel < NL && w.entry_addr < ML)
          bias_mem[w.layer_sel*ML + w.entry_addr] = w.data_value[15:0];
      end
      OP_FEATURE: begin
        if (w.entry_addr < NIN) feature_mem[w.entry_addr] = w.data_value;
      end
      default: begin
        evaluate_network();
        runs_seen++;
        for (int k = 0; k < NOUT; k++) begin
          o.out_index = 5'(k);
          o.out_value = prev_act[k % BUF_DEPTH];
          o.out_last = (k + 1 == NOUT);
          expected_outputs.push_back(o);
        end
      end
    endcase
  endfunction

  // Driver.
  always @(posedge clk) begin : drive
    logic nx_start;
    logic nx_cv;
    in_word_t nx_req;
    logic [2:0] nx_idx;
    logic [15:0] nx_data;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      request <= '0;
      cfg_index <= '0;
      cfg_data <= '0;
      cur_valid = 1'b0;
      wait_cnt = 0;
    end else begin
      nx_start = start;
      nx_cv = cfg_valid;
      nx_req = request;
      nx_idx = cfg_index;
      nx_data = cfg_data;
      if (start && !busy) nx_start = 1'b0;
      if (cfg_valid && cfg_ready) nx_cv = 1'b0;
      if (!nx_start && !nx_cv) begin
        if (!cur_valid && pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          cur_valid = 1'b1;
          wait_cnt = cur.gap;
        end
        if (cur_valid) begin
          if (wait_cnt > 0) begin
            wait_cnt = wait_cnt - 1;
          end else begin
            case (cur.kind)
              K_WORD: begin
                nx_start = 1'b1;
                nx_req = cur.word;
                cur_valid = 1'b0;
              end
              K_CFG: begin
                nx_cv = 1'b1;
                nx_idx = cur.idx;
                nx_data = cur.data;
                cur_valid = 1'b0;
              end
              K_DRAIN: begin
                if (expected_outputs.size() == 0 && !busy) begin
                  cur.kind = K_HOLD;
                  wait_cnt = 20;
                end
              end
              default: cur_valid = 1'b0;
            endcase
          end
        end
      end
      start <= nx_start;
      cfg_valid <= nx_cv;
      request <= nx_req;
      cfg_index <= nx_idx;
      cfg_data <= nx_data;
    end
  end

  // Accepted words and register writes feed the predictor.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_word(request);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < 4) size_reg[cfg_index] = cfg_data[5:0];
        else if (cfg_index == CFG_SCALE) scale_reg = cfg_data;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin : monitor
    out_word_t e;
    if (!rst && done) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected word: got index %0d value %0d last %0b", $time,
                 result.out_index, result.out_value, result.out_last);
        errors++;
      end else begin
        e = expected_outputs.pop_front();
        words_checked++;
        if (result.out_index !== e.out_index) begin
          $display("%0t: out_index mismatch: expected %0d actual %0d", $time,
                   e.out_index, result.out_index);
          errors++;
        end
        if (result.out_value !== e.out_value) begin
          $display("%0t: out_value mismatch (index %0d): expected %0d actual %0d", $time,
                   e.out_index, e.out_value, result.out_value);
          errors++;
        end
        if (result.out_last !== e.out_last) begin
          $display("%0t: out_last mismatch (index %0d): expected %0b actual %0b", $time,
                   e.out_index, e.out_last, result.out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_point_mlp_inference_core_tb: FAIL");
      $finish;
    end
  end

  task automatic push_word(opcode_t op, int lsel, int addr, logic [31:0] data, int gap);
    pending_t p;
    p.kind = K_WORD;
    p.word.opcode = op;
    p.word.layer_sel = 2'(lsel);
    p.word.entry_addr = 10'(addr);
    p.word.data_value = data;
    p.idx = '0;
    p.data = '0;
    p.gap = gap;
    pend_q.push_back(p);
  endtask

  task automatic push_cfg(int idx, logic [15:0] data);
    pending_t p;
    p.kind = K_CFG;
    p.word = '0;
    p.idx = 3'(idx);
    p.data = data;
    p.gap = $urandom_range(0, 3);
    pend_q.push_back(p);
  endtask

  task automatic push_drain();
    pending_t p;
    p.kind = K_DRAIN;
    p.word = '0;
    p.idx = '0;
    p.data = '0;
    p.gap = 2;
    pend_q.push_back(p);
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 400)) - 200);
      2: return 32'($signed($urandom_range(0, 20000)) - 10000);
      default: return {{16{1'b0}}, 16'($urandom)};
    endcase
  endfunction

  function automatic int rand_gap(bit quick);
    return quick ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic random_phase(int n_words, int run_pct, bit quick);
    int r;
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(0, 99);
      if (r < run_pct)
        push_word(OP_RUN, $urandom_range(0, 3), $urandom_range(0, 1023), $urandom,
                  rand_gap(quick));
      else if (r < run_pct + 35)
        push_word(OP_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 1023), rand_data(),
                  rand_gap(quick));
      else if (r < run_pct + 60)
        push_word(OP_BIAS, $urandom_range(0, 3),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31),
                  rand_data(), rand_gap(quick));
      else
        push_word(OP_FEATURE, $urandom_range(0, 3),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31),
                  rand_data(), rand_gap(quick));
    end
  endtask

  task automatic set_sizes(int s0, int s1, int s2, int s3, int sc);
    push_drain();
    push_cfg(CFG_SIZE0, {10'($urandom), 6'(s0)});
    push_cfg(CFG_SIZE1, {10'($urandom), 6'(s1)});
    push_cfg(CFG_SIZE2, {10'($urandom), 6'(s2)});
    push_cfg(CFG_SIZE3, {10'($urandom), 6'(s3)});
    push_cfg(CFG_SCALE, 16'(sc));
  endtask

  initial begin
    for (int i = 0; i < NL*WSLICE; i++) weight_mem[i] = '0;
    for (int i = 0; i < NL*ML; i++) bias_mem[i] = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      feature_mem[i] = '0;
      prev_act[i] = '0;
      curr_act[i] = '0;
    end
    size_reg[0] = SIZE0_RST;
    size_reg[1] = SIZE1_RST;
    size_reg[2] = SIZE2_RST;
    size_reg[3] = SIZE3_RST;
    scale_reg = SCALE_RST;

    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    request = '0;
    cfg_index = '0;
    cfg_data = '0;

    // Every entry that the layer sizes used below can read is loaded before any run.
    for (int i = 0; i < NIN; i++) push_word(OP_FEATURE, i % 4, i, rand_data(), rand_gap(i > 8));
    for (int l = 0; l < NL; l++)
      for (int i = 0; i < ((l == 0) ? 4 : ML); i++)
        push_word(OP_BIAS, l, i, rand_data(), rand_gap(i % 2 == 0));
    for (int l = 0; l < NL; l++)
      for (int i = 0; i < ((l == 0) ? 128 : ((l == 1) ? 32 : 96)); i++)
        push_word(OP_WEIGHT, l, i, ($urandom_range(0, 1) == 0) ? rand_data() : 32'(i % 7),
                  rand_gap(i % 2 == 0));

    // Directed words: extremes and ignored writes, then two runs.
    set_sizes(4, 4, 5, 3, 100);
    push_word(OP_FEATURE, 0, 0, 32'h8000_0000, 0);
    push_word(OP_FEATURE, 3, 31, 32'h7FFF_FFFF, 1);
    push_word(OP_FEATURE, 1, 1, 32'hFFFF_FFFF, 0);
    push_word(OP_FEATURE, 2, 2, 32'h0000_0000, 3);
    push_word(OP_FEATURE, 0, 32, 32'h1234_5678, 0);
    push_word(OP_FEATURE, 0, 1023, 32'hDEAD_BEEF, 0);
    push_word(OP_WEIGHT, 3, 5, 32'h0000_7777, 0);
    push_word(OP_WEIGHT, 2, 1023, 32'hFFFF_8000, 0);
    push_word(OP_WEIGHT, 0, 0, 32'h0000_7FFF, 0);
    push_word(OP_BIAS, 3, 0, 32'h0000_1111, 0);
    push_word(OP_BIAS, 1, 32, 32'h0000_2222, 0);
    push_word(OP_BIAS, 0, 1023, 32'h0000_3333, 0);
    push_word(OP_BIAS, 2, 31, 32'hABCD_8000, 0);
    push_word(OP_RUN, 0, 0, 32'h0, 5);
    push_word(OP_RUN, 3, 1023, 32'hFFFF_FFFF, 0);

    // Zero sizes count as one, oversize as the maximum; scale of zero divides by one.
    set_sizes(0, 0, 0, 0, 0);
    push_cfg(5, 16'hFFFF);
    push_cfg(7, 16'h0001);
    push_word(OP_RUN, 0, 0, 32'h0, 0);
    set_sizes(1, 63, 1, 63, 1);
    push_word(OP_RUN, 0, 0, 32'h0, 0);
    set_sizes(2, 3, 32, 1, 65535);
    push_word(OP_RUN, 0, 0, 32'h0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      set_sizes($urandom_range(0, 4), $urandom_range(1, 4), $urandom_range(1, 5),
                $urandom, (ph == 3) ? 0 : ((ph == 5) ? 65535 : $urandom_range(1, 1000)));
      random_phase(10, 20, ph % 3 == 1);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pend_q.size() > 0 || cur_valid || start || cfg_valid || expected_outputs.size() > 0);
    repeat (60) @(posedge clk);

    if (expected_outputs.size() > 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_outputs.size());
      errors++;
    end
    $display("Covered %0d runs and %0d output words over %0d cycles, with layer sizes,",
             runs_seen, words_checked, cycles);
    $display("scale extremes and ignored writes exercised; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("fixed_point_mlp_inference_core_tb: PASS");
    end else begin
      $display("fixed_point_mlp_inference_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[fixed_point_mlp_inference_core.f]
src/fpmlp_pkg.sv
src/fpmlp_ram.sv
src/fpmlp_datapath.sv
src/fpmlp_ctrl.sv
src/fixed_point_mlp_inference_core.sv
src/fpmlp_checker.sv
sim/fixed_point_mlp_inference_core_tb.sv
